### hw/rtl/stream_byte_reassembler_assert.svh
// Assertion macros used by the reassembler datapath.
`ifndef STREAM_BYTE_REASSEMBLER_ASSERT_SVH
`define STREAM_BYTE_REASSEMBLER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SBR_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define SBR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SBR_ASSERT(lbl, expr, msg)
`define SBR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/sbr_pkg.sv
// Types and constants of the stream byte reassembler.
`default_nettype none
package sbr_pkg;
  localparam int IDX_W  = 64;
  localparam int BYTE_W = 8;
  localparam int PEND_W = 13;

  localparam logic [1:0] MODE_SEG = 2'd0;
  localparam logic [1:0] MODE_END = 2'd1;
  localparam logic [1:0] MODE_POP = 2'd2;
  localparam logic [1:0] MODE_NOP = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_OUT   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic [1:0] SEL_IDX  = 2'd0;
  localparam logic [1:0] SEL_ASM  = 2'd1;
  localparam logic [1:0] SEL_READ = 2'd2;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       check1;
    logic       check2;
    logic       slot;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       store_asm;
    logic       store_held;
    logic       absorb;
    logic       pop;
    logic       set_status;
    logic [1:0] status;
    logic       close;
  } sbr_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       dup;
    logic       past;
    logic       win_out;
    logic       hit;
    logic       pop_ok;
    logic       mark;
    logic       absorb_ok;
    logic       clr_last;
  } sbr_sts_t;
endpackage
`default_nettype wire

### hw/rtl/sbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sbr_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### hw/rtl/sbr_datapath.sv
// Pointers, counters, ring memory and result registers of the reassembler.
`default_nettype none
module sbr_datapath #(
  parameter int WINDOW = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire sbr_pkg::sbr_cmd_t             cmd,
  output sbr_pkg::sbr_sts_t                  sts,
  input  wire logic [1:0]                    mode,
  input  wire logic [sbr_pkg::IDX_W-1:0]     stream_index,
  input  wire logic [sbr_pkg::BYTE_W-1:0]    data_byte,
  input  wire logic                          segment_final,
  output logic      [1:0]                    byte_status,
  output logic      [sbr_pkg::BYTE_W-1:0]    popped_byte,
  output logic      [sbr_pkg::IDX_W-1:0]     assembled_point,
  output logic      [sbr_pkg::PEND_W-1:0]    pending_count,
  output logic                               stream_closed
);
  import sbr_pkg::*;

  localparam int AW = $clog2(WINDOW);
  localparam int DW = BYTE_W + 1;
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  logic [1:0]        item_mode;
  logic [IDX_W-1:0]  item_idx;
  logic [BYTE_W-1:0] item_byte;
  logic [IDX_W-1:0]  rd_point;
  logic [IDX_W-1:0]  asm_index;
  logic [IDX_W-1:0]  end_index;
  logic              end_known;
  logic [AW-1:0]     held_total;
  logic [AW-1:0]     read_slot;
  logic [AW-1:0]     asm_slot;
  logic [AW-1:0]     idx_slot;
  logic [AW-1:0]     clr_cnt;
  logic [IDX_W-1:0]  diff;
  logic              dup, past, win_out, hit, pop_ok;
  logic [AW:0]       slot_sum;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DW-1:0]     wdata;
  logic [AW-1:0]     raddr;
  logic [DW-1:0]     rdata;

  always_comb begin
    slot_sum = {1'b0, read_slot} + {1'b0, diff[AW-1:0]};
    if (slot_sum >= (AW+1)'(WINDOW)) begin
      slot_sum = slot_sum - (AW+1)'(WINDOW);
    end
  end

  always_comb begin
    we    = cmd.clear | cmd.store_asm | cmd.store_held | cmd.absorb;
    waddr = idx_slot;
    wdata = {1'b0, item_byte};
    priority if (cmd.clear) begin
      waddr = clr_cnt;
      wdata = '0;
    end else if (cmd.absorb) begin
      waddr = asm_slot;
      wdata = {1'b0, rdata[BYTE_W-1:0]};
    end else if (cmd.store_held) begin
      wdata = {1'b1, item_byte};
    end else begin
      wdata = {1'b0, item_byte};
    end
  end

  always_comb begin
    unique case (cmd.rd_sel)
      SEL_ASM:  raddr = asm_slot;
      SEL_READ: raddr = read_slot;
      default:  raddr = idx_slot;
    endcase
  end

  sbr_ram #(.WIDTH(DW), .DEPTH(WINDOW)) u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_point    <= '0;
      asm_index   <= '0;
      end_index   <= '0;
      end_known   <= 1'b0;
      held_total  <= '0;
      read_slot   <= '0;
      asm_slot    <= '0;
      clr_cnt     <= '0;
      byte_status <= ST_OK;
      popped_byte <= '0;
      stream_closed <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.load) begin
        item_mode   <= mode;
        item_idx    <= stream_index;
        item_byte   <= data_byte;
        byte_status <= ST_OK;
        popped_byte <= '0;
        if (mode == MODE_SEG && segment_final) begin
          end_index <= (stream_index == IDX_MAX) ? IDX_MAX : stream_index + 64'd1;
          end_known <= 1'b1;
        end else if (mode == MODE_END) begin
          end_index <= stream_index;
          end_known <= 1'b1;
        end
      end
      if (cmd.check1) begin
        dup    <= item_idx < asm_index;
        past   <= end_known && (item_idx >= end_index);
        pop_ok <= rd_point < asm_index;
      end
      if (cmd.check2) begin
        diff    <= item_idx - rd_point;
        win_out <= (item_idx == IDX_MAX) || ((item_idx - rd_point) >= IDX_W'(WINDOW));
        hit     <= item_idx == asm_index;
      end
      if (cmd.slot) begin
        idx_slot <= slot_sum[AW-1:0];
      end
      if (cmd.store_asm || cmd.absorb) begin
        asm_index <= asm_index + 64'd1;
        asm_slot  <= (asm_slot == AW'(WINDOW - 1)) ? '0 : asm_slot + AW'(1);
      end
      if ((cmd.store_asm && rdata[BYTE_W]) || cmd.absorb) begin
        held_total <= held_total - AW'(1);
      end else if (cmd.store_held) begin
        held_total <= held_total + AW'(1);
      end
      if (cmd.pop) begin
        popped_byte <= rdata[BYTE_W-1:0];
        rd_point    <= rd_point + 64'd1;
        read_slot   <= (read_slot == AW'(WINDOW - 1)) ? '0 : read_slot + AW'(1);
      end
      if (cmd.set_status) begin
        byte_status <= cmd.status;
      end
      if (cmd.close) begin
        stream_closed <= end_known && (asm_index >= end_index);
      end
    end
  end

  always_comb begin
    sts.mode      = item_mode;
    sts.dup       = dup;
    sts.past      = past;
    sts.win_out   = win_out;
    sts.hit       = hit;
    sts.pop_ok    = pop_ok;
    sts.mark      = rdata[BYTE_W];
    sts.absorb_ok = (held_total != '0) && (asm_index != IDX_MAX);
    sts.clr_last  = clr_cnt == AW'(WINDOW - 1);
  end

  assign assembled_point = asm_index;
  assign pending_count   = PEND_W'(held_total);

`include "stream_byte_reassembler_assert.svh"
  `SBR_ASSERT(a_order, rd_point <= asm_index, "read point passed assembled point")
  `SBR_ASSERT(a_span, (asm_index - rd_point) <= IDX_W'(WINDOW), "assembled span exceeds ring")
  `SBR_ASSERT_NEXT(a_absorb, cmd.absorb, asm_index == $past(asm_index) + 64'd1, "absorb did not advance")
endmodule
`default_nettype wire

### hw/rtl/sbr_ctrl.sv
// Controller state machine that sequences each transfer through the datapath.
`default_nettype none
module sbr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  output logic                   done,
  output sbr_pkg::sbr_cmd_t      cmd,
  input  wire sbr_pkg::sbr_sts_t sts
);
  import sbr_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHK1  = 4'd2;
  localparam logic [3:0] S_CHK2  = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_RDI   = 4'd5;
  localparam logic [3:0] S_RDW   = 4'd6;
  localparam logic [3:0] S_ABS   = 4'd7;
  localparam logic [3:0] S_ABSW  = 4'd8;
  localparam logic [3:0] S_POPW  = 4'd9;
  localparam logic [3:0] S_CLOSE = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = SEL_IDX;
    cmd.status = ST_OK;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHK1;
        end
      end
      S_CHK1: begin
        cmd.check1 = 1'b1;
        state_next = S_CHK2;
      end
      S_CHK2: begin
        cmd.check2 = 1'b1;
        if (sts.mode == MODE_SEG) begin
          state_next = S_DEC;
        end else if (sts.mode == MODE_POP) begin
          if (sts.pop_ok) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = SEL_READ;
            state_next = S_POPW;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_EMPTY;
            state_next     = S_CLOSE;
          end
        end else begin
          state_next = S_CLOSE;
        end
      end
      S_DEC: begin
        cmd.slot = 1'b1;
        if (sts.dup) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_DUP;
          state_next     = S_CLOSE;
        end else if (sts.past || sts.win_out) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_OUT;
          state_next     = S_CLOSE;
        end else begin
          state_next = S_RDI;
        end
      end
      S_RDI: begin
        cmd.rd_en  = 1'b1;
        state_next = S_RDW;
      end
      S_RDW: begin
        if (sts.hit) begin
          cmd.store_asm = 1'b1;
          state_next    = S_ABS;
        end else if (sts.mark) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_DUP;
          state_next     = S_CLOSE;
        end else begin
          cmd.store_held = 1'b1;
          state_next     = S_CLOSE;
        end
      end
      S_ABS: begin
        if (sts.absorb_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = SEL_ASM;
          state_next = S_ABSW;
        end else begin
          state_next = S_CLOSE;
        end
      end
      S_ABSW: begin
        if (sts.mark) begin
          cmd.absorb = 1'b1;
          state_next = S_ABS;
        end else begin
          state_next = S_CLOSE;
        end
      end
      S_POPW: begin
        cmd.pop    = 1'b1;
        state_next = S_CLOSE;
      end
      S_CLOSE: begin
        cmd.close  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;
endmodule
`default_nettype wire

### hw/rtl/stream_byte_reassembler.sv
// Top level of the stream byte reassembler: controller plus datapath.
// A result strobes on done after a marker, no-op or pop transfer, after a drop, after a byte
// held out of order or found already held, and after an in-order byte once it has absorbed
// the held bytes behind it; the scan stops at an empty slot or when no byte is held.
// One transfer is in flight at a time; busy falls after done.
// After rst the block sweeps every slot of the ring, busy high, to clear the held marks.
`default_nettype none
module stream_byte_reassembler #(
  parameter int WINDOW = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 mode,
  input  wire logic [sbr_pkg::IDX_W-1:0]  stream_index,
  input  wire logic [sbr_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                       segment_final,
  output logic                            done,
  output logic      [1:0]                 byte_status,
  output logic      [sbr_pkg::BYTE_W-1:0] popped_byte,
  output logic      [sbr_pkg::IDX_W-1:0]  assembled_point,
  output logic      [sbr_pkg::PEND_W-1:0] pending_count,
  output logic                            stream_closed
);
  import sbr_pkg::*;

  sbr_cmd_t cmd;
  sbr_sts_t sts;

  sbr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  sbr_datapath #(.WINDOW(WINDOW)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .mode            (mode),
    .stream_index    (stream_index),
    .data_byte       (data_byte),
    .segment_final   (segment_final),
    .byte_status     (byte_status),
    .popped_byte     (popped_byte),
    .assembled_point (assembled_point),
    .pending_count   (pending_count),
    .stream_closed   (stream_closed)
  );
endmodule
`default_nettype wire
